### rtl/rad_pkg.sv
// Shared types, constants and byte helpers for the response acknowledgment detector.
package rad_pkg;

  localparam int HistDepth = 14;
  localparam int ViewLen = HistDepth + 1;
  localparam int CountW = 9;
  localparam int CountSat = 511;
  localparam int MaxResponseBytesDef = 512;

  localparam int OkPhraseLen = 12;
  localparam int ErrPhraseLen = 15;
  localparam int OkWordLen = 2;
  localparam int ErrWordLen = 5;

  // Byte k from the least significant end is the character k places before the newest byte.
  localparam logic [OkPhraseLen*8-1:0] OkPhrase = "response: ok";
  localparam logic [ErrPhraseLen*8-1:0] ErrPhrase = "response: error";
  localparam logic [OkWordLen*8-1:0] OkWord = "ok";
  localparam logic [ErrWordLen*8-1:0] ErrWord = "error";

  typedef enum logic [1:0] {
    STATUS_PENDING = 2'd0,
    STATUS_OK      = 2'd1,
    STATUS_ERROR   = 2'd2
  } status_e;

  typedef struct packed {
    logic       start_flag;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic              ack_ok;
    logic              ack_err;
    logic [CountW-1:0] response_length;
  } out_item_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

endpackage

### rtl/rad_stream_if.sv
// Valid/ready stream interface that carries one item per handshake.
interface rad_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/response_ack_detector_unit.sv
// Top level of the response acknowledgment detector.
// Path: each item is held in the input register and then in the result register.
// Throughput: one item per cycle while the output is not stalled; the history window and flags update in a single pass.
// Reset: asynchronous, active low; history, byte count, flags and both stage valids clear.
// Ready is released whenever the input stage is empty or moves into the result register.
module response_ack_detector_unit #(
  parameter int MAX_RESPONSE_BYTES = rad_pkg::MaxResponseBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rad_stream_if.sink    in_i,
  rad_stream_if.source  out_o
);

  localparam int CaptureLimit = (MAX_RESPONSE_BYTES - 1 < rad_pkg::CountSat) ?
                                (MAX_RESPONSE_BYTES - 1) : rad_pkg::CountSat;
  localparam int HD = rad_pkg::HistDepth;
  localparam int VL = rad_pkg::ViewLen;
  localparam int CW = rad_pkg::CountW;

  logic              s1_valid_q;
  rad_pkg::in_item_t s1_item_q;
  logic              out_valid_q;
  rad_pkg::out_item_t out_q;
  rad_pkg::out_item_t out_d;

  logic [7:0]    hist_q [HD];
  logic [7:0]    hist_d [HD];
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic          ok_seen_q;
  logic          ok_seen_d;
  logic          err_seen_q;
  logic          err_seen_d;

  logic          out_free;
  logic          step;
  logic          in_take;

  logic [7:0]    hist_eff [HD];
  logic [CW-1:0] count_eff;
  logic          ok_eff;
  logic          err_eff;
  logic          capture;
  logic [7:0]    view [VL];
  logic [7:0]    fv [VL];
  logic          an [VL];

  logic          ok_phrase_hit;
  logic          err_phrase_hit;
  logic          ok_word_done;
  logic          err_word_done;
  logic          ok_word_end;
  logic          err_word_end;
  logic          ok_now;
  logic          err_now;

  assign out_free = !out_valid_q || out_o.ready;
  assign step = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_take = in_i.valid && in_i.ready;

  always_comb begin
    for (int k = 0; k < HD; k++) begin
      hist_eff[k] = s1_item_q.start_flag ? 8'd0 : hist_q[k];
    end
    count_eff = s1_item_q.start_flag ? '0 : count_q;
    ok_eff = s1_item_q.start_flag ? 1'b0 : ok_seen_q;
    err_eff = s1_item_q.start_flag ? 1'b0 : err_seen_q;
    capture = count_eff < CW'(CaptureLimit);

    if (capture) begin
      view[0] = s1_item_q.data_byte;
      for (int k = 0; k < HD; k++) begin
        view[k+1] = hist_eff[k];
      end
    end else begin
      for (int k = 0; k < HD; k++) begin
        view[k] = hist_eff[k];
      end
      view[VL-1] = 8'd0;
    end

    for (int k = 0; k < VL; k++) begin
      fv[k] = rad_pkg::fold(view[k]);
      an[k] = rad_pkg::is_alnum(view[k]);
    end
  end

  always_comb begin
    ok_phrase_hit = 1'b1;
    for (int k = 0; k < rad_pkg::OkPhraseLen; k++) begin
      if (fv[k] != rad_pkg::OkPhrase[8*k +: 8]) begin
        ok_phrase_hit = 1'b0;
      end
    end
    err_phrase_hit = 1'b1;
    for (int k = 0; k < rad_pkg::ErrPhraseLen; k++) begin
      if (fv[k] != rad_pkg::ErrPhrase[8*k +: 8]) begin
        err_phrase_hit = 1'b0;
      end
    end

    ok_word_done = !an[0] && !an[rad_pkg::OkWordLen+1];
    ok_word_end = !an[rad_pkg::OkWordLen];
    for (int k = 0; k < rad_pkg::OkWordLen; k++) begin
      if (fv[k+1] != rad_pkg::OkWord[8*k +: 8]) begin
        ok_word_done = 1'b0;
      end
      if (fv[k] != rad_pkg::OkWord[8*k +: 8]) begin
        ok_word_end = 1'b0;
      end
    end

    err_word_done = !an[0] && !an[rad_pkg::ErrWordLen+1];
    err_word_end = !an[rad_pkg::ErrWordLen];
    for (int k = 0; k < rad_pkg::ErrWordLen; k++) begin
      if (fv[k+1] != rad_pkg::ErrWord[8*k +: 8]) begin
        err_word_done = 1'b0;
      end
      if (fv[k] != rad_pkg::ErrWord[8*k +: 8]) begin
        err_word_end = 1'b0;
      end
    end
  end

  always_comb begin
    ok_seen_d = ok_eff || (capture && (ok_phrase_hit || ok_word_done));
    err_seen_d = err_eff || (capture && (err_phrase_hit || err_word_done));
    if (capture) begin
      hist_d[0] = s1_item_q.data_byte;
      for (int k = 1; k < HD; k++) begin
        hist_d[k] = hist_eff[k-1];
      end
      count_d = count_eff + CW'(1);
    end else begin
      hist_d = hist_eff;
      count_d = count_eff;
    end

    ok_now = ok_seen_d || ok_word_end;
    err_now = err_seen_d || err_word_end;

    if (err_now) begin
      out_d.status = rad_pkg::STATUS_ERROR;
    end else if (ok_now) begin
      out_d.status = rad_pkg::STATUS_OK;
    end else begin
      out_d.status = rad_pkg::STATUS_PENDING;
    end
    out_d.ack_ok = ok_now;
    out_d.ack_err = err_now;
    out_d.response_length = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q <= '0;
      ok_seen_q <= 1'b0;
      err_seen_q <= 1'b0;
      for (int k = 0; k < HD; k++) begin
        hist_q[k] <= 8'd0;
      end
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (step) begin
        count_q <= count_d;
        ok_seen_q <= ok_seen_d;
        err_seen_q <= err_seen_d;
        hist_q <= hist_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_i.payload;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

`ifndef NO_ASSERTIONS
  a_length_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.response_length <= CW'(CaptureLimit))
    else $error("Response length is beyond the capture limit.");

  a_status_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.status == rad_pkg::STATUS_ERROR) == out_q.ack_err) &&
      ((out_q.status == rad_pkg::STATUS_OK) == (out_q.ack_ok && !out_q.ack_err)))
    else $error("Status does not agree with the acknowledgment flags.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !s1_item_q.start_flag && count_q < CW'(CaptureLimit)) |=>
      count_q == $past(count_q) + CW'(1))
    else $error("Byte count did not advance on a captured item.");

  a_flag_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !s1_item_q.start_flag && err_seen_q) |=> err_seen_q)
    else $error("Error flag cleared without a start mark.");
`endif

endmodule

### bench/response_ack_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the detector's acknowledgment status per byte and compares every result.
module response_ack_checker
  import rad_pkg::*;
#(
  parameter int MAX_BYTES = MaxResponseBytesDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rad_stream_if in_mon,
  rad_stream_if out_mon,
  output int    errors_o,
  output int    pending_o
);

  localparam int CaptureLimit = (MAX_BYTES - 1 < CountSat) ? MAX_BYTES - 1 : CountSat;

  logic [7:0]        window_q [HistDepth];
  logic [CountW-1:0] count_q;
  logic              ok_q;
  logic              err_q;
  out_item_t         ack_expected_q [$];
  out_item_t         ack_want;
  out_item_t         ack_got;
  int                mismatches = 0;
  int                waiting = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  // The view holds the newest byte at index zero; the text is matched backward from index at.
  function automatic logic spells(input logic [7:0] v [ViewLen], input int at,
                                  input logic [ErrPhraseLen*8-1:0] pat, input int len);
    for (int k = 0; k < len; k++) begin
      if (to_lower(v[at+k]) != pat[8*k +: 8]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void clear_response();
    foreach (window_q[k]) begin
      window_q[k] = 8'h00;
    end
    count_q = '0;
    ok_q    = 1'b0;
    err_q   = 1'b0;
  endfunction

  function automatic out_item_t predict_ack(input in_item_t it);
    logic [7:0] v [ViewLen];
    logic       ok_now;
    logic       err_now;
    out_item_t  r;
    if (it.start_flag) begin
      clear_response();
    end
    if (count_q < CaptureLimit) begin
      v[0] = it.data_byte;
      for (int k = 0; k < HistDepth; k++) begin
        v[k+1] = window_q[k];
      end
      if (spells(v, 0, OkPhrase, OkPhraseLen) ||
          (!word_char(v[0]) && spells(v, 1, OkWord, OkWordLen) &&
           !word_char(v[OkWordLen+1]))) begin
        ok_q = 1'b1;
      end
      if (spells(v, 0, ErrPhrase, ErrPhraseLen) ||
          (!word_char(v[0]) && spells(v, 1, ErrWord, ErrWordLen) &&
           !word_char(v[ErrWordLen+1]))) begin
        err_q = 1'b1;
      end
      for (int k = HistDepth - 1; k > 0; k--) begin
        window_q[k] = window_q[k-1];
      end
      window_q[0] = it.data_byte;
      count_q = count_q + 1'b1;
    end else begin
      // A full response drops the byte; the status is that of the stored bytes.
      for (int k = 0; k < HistDepth; k++) begin
        v[k] = window_q[k];
      end
      v[HistDepth] = 8'h00;
    end
    ok_now  = ok_q || (spells(v, 0, OkWord, OkWordLen) && !word_char(v[OkWordLen]));
    err_now = err_q || (spells(v, 0, ErrWord, ErrWordLen) && !word_char(v[ErrWordLen]));
    r.status          = err_now ? STATUS_ERROR : (ok_now ? STATUS_OK : STATUS_PENDING);
    r.ack_ok          = ok_now;
    r.ack_err         = err_now;
    r.response_length = count_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_response();
      ack_expected_q.delete();
      waiting = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        ack_got = out_mon.payload;
        if (ack_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d length %0d",
                   $time, ack_got.status, ack_got.response_length);
          mismatches++;
        end else begin
          ack_want = ack_expected_q.pop_front();
          if (ack_got.status !== ack_want.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, ack_want.status, ack_got.status);
            mismatches++;
          end
          if (ack_got.ack_ok !== ack_want.ack_ok) begin
            $display("%0t: ack_ok expected %0b, actual %0b",
                     $time, ack_want.ack_ok, ack_got.ack_ok);
            mismatches++;
          end
          if (ack_got.ack_err !== ack_want.ack_err) begin
            $display("%0t: ack_err expected %0b, actual %0b",
                     $time, ack_want.ack_err, ack_got.ack_err);
            mismatches++;
          end
          if (ack_got.response_length !== ack_want.response_length) begin
            $display("%0t: response_length expected %0d, actual %0d",
                     $time, ack_want.response_length, ack_got.response_length);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        ack_expected_q.push_back(predict_ack(in_mon.payload));
      end
      waiting = ack_expected_q.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the detector's testbench: clock, reset, byte stimulus, result stalls and the verdict.
module testbench;
  import rad_pkg::*;

  localparam int MaxBytes = MaxResponseBytesDef;
  localparam int CaptureLimit = (MaxBytes - 1 < CountSat) ? MaxBytes - 1 : CountSat;
  localparam int TargetItems = 1850;
  localparam int HoldCycles = 150;
  localparam string AlnumChars = "0123456789AZaorekz";

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  rad_stream_if #(.payload_t(in_item_t))  in_if ();
  rad_stream_if #(.payload_t(out_item_t)) out_if ();

  int         fail_count;
  int         pending_acks;
  int         bytes_sent = 0;
  int         responses_sent = 0;
  int         hold_requests = 0;
  int         hold_served = 0;
  int         hold_left = 0;
  logic       quiet_phase = 1'b0;
  logic [7:0] resp_bytes [$];

  response_ack_detector_unit #(
    .MAX_RESPONSE_BYTES(MaxBytes)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  response_ack_checker #(
    .MAX_BYTES(MaxBytes)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .errors_o (fail_count),
    .pending_o(pending_acks)
  );

  function automatic void add_text(input string s, input logic mixed);
    logic [7:0] c;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if (mixed && c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) begin
        c = c - 8'd32;
      end
      resp_bytes.push_back(c);
    end
  endfunction

  function automatic void build_response();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0: add_text("response: ok", 1'b1);
        1: add_text("response: error", 1'b1);
        2: add_text("ok", 1'b1);
        3: add_text("error", 1'b1);
        4: add_text(" ", 1'b0);
        5: begin
          resp_bytes.push_back(8'h0D);
          resp_bytes.push_back(8'h0A);
        end
        6: resp_bytes.push_back(8'($urandom_range(33, 47)));
        7: resp_bytes.push_back(AlnumChars[$urandom_range(0, AlnumChars.len() - 1)]);
        8: resp_bytes.push_back(8'($urandom_range(0, 255)));
        9: add_text("response: ", 1'b1);
        10: add_text("respons", 1'b1);
        default: add_text("err", 1'b1);
      endcase
    end
  endfunction

  task automatic send_item(input logic first, input logic [7:0] b);
    while (!quiet_phase && $urandom_range(0, 99) < 12) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= in_item_t'{start_flag: first, data_byte: b};
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_response(input logic with_start, input logic strays);
    foreach (resp_bytes[k]) begin
      send_item((k == 0) ? with_start : (strays && $urandom_range(0, 49) == 0), resp_bytes[k]);
    end
    resp_bytes.delete();
    responses_sent++;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (quiet_phase) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= 12);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic held;
    logic paused;
    logic long_done;
    held = 1'b0;
    paused = 1'b0;
    long_done = 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    out_if.ready  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes right after reset carry no start mark.
    add_text("ok!", 1'b0);
    send_response(1'b0, 1'b0);
    add_text("oK9", 1'b0);
    send_response(1'b1, 1'b0);
    add_text("Error", 1'b0);
    resp_bytes.push_back(8'h0D);
    send_response(1'b1, 1'b0);
    add_text("zok", 1'b0);
    send_response(1'b1, 1'b0);
    add_text("ok error", 1'b0);
    send_response(1'b1, 1'b0);
    resp_bytes.push_back(8'hFF);
    resp_bytes.push_back(8'h00);
    send_response(1'b1, 1'b0);

    while (bytes_sent < TargetItems) begin
      if (!held && bytes_sent >= 400) begin
        hold_requests <= hold_requests + 1;
        held = 1'b1;
      end
      if (!long_done && bytes_sent >= 700) begin
        // A standalone OK ends exactly at the capture limit; the trailing letters are dropped.
        repeat (CaptureLimit - 3) resp_bytes.push_back(8'($urandom_range(32, 126)));
        resp_bytes.push_back(8'h20);
        add_text("OK", 1'b0);
        add_text("zzzz", 1'b0);
        send_response(1'b1, 1'b0);
        long_done = 1'b1;
      end else begin
        build_response();
        send_response($urandom_range(0, 9) != 0, 1'b1);
      end
      if (!paused && bytes_sent >= 1000) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_acks != 0);
        paused = 1'b1;
      end
      quiet_phase <= (bytes_sent >= 1200 && bytes_sent < 1500);
    end

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_acks != 0);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d bytes in %0d responses: OK and ERROR words and phrases in mixed case,",
             bytes_sent, responses_sent);
    $display("stray start marks, a saturated response, a long output stall and a full drain.");
    if (fail_count == 0 && pending_acks == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rad_pkg.sv
rtl/rad_stream_if.sv
rtl/response_ack_detector_unit.sv
bench/response_ack_checker.sv
bench/testbench.sv
